/* rtl/esc_calibration_sequencer_core_macros.svh */
// Assertion macros shared by the ESC calibration sequencer RTL.
// Stand-alone header; the clock is clk and the synchronous reset is rst_n.
`ifndef ESC_CALIBRATION_SEQUENCER_CORE_MACROS_SVH
`define ESC_CALIBRATION_SEQUENCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define ESC_CAL_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esc_cal assertion failed");
// Next-cycle implication, checked out of reset
`define ESC_CAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esc_cal assertion failed");
`else
`define ESC_CAL_ASSERT(label, ante, cons)
`define ESC_CAL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/esc_cal_pkg.sv */
// Types, codes and constants of the ESC calibration sequencer.
// No dependencies; used by every RTL module of the block.
package esc_cal_pkg;

  localparam int CMD_W   = 12;
  localparam int MODE_W  = 5;
  localparam int TICK_W  = 32;
  localparam int HOLD_W  = 16;
  localparam int FINE_W  = 8;
  localparam int COARSE_W = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_IDLE        = 5'd0;
  localparam logic [MODE_W-1:0] MODE_CAL_MAX     = 5'd1;
  localparam logic [MODE_W-1:0] MODE_CAL_MIN     = 5'd2;
  localparam logic [MODE_W-1:0] MODE_FIRST_MOTOR = 5'd3;
  localparam logic [MODE_W-1:0] MODE_TEST        = 5'd19;

  // Phase of a per-motor mode
  localparam logic [1:0] PH_MIN_SEARCH = 2'd0;
  localparam logic [1:0] PH_MIN_END    = 2'd1;
  localparam logic [1:0] PH_MAX_SEARCH = 2'd2;
  localparam logic [1:0] PH_MAX_END    = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COMMAND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COMMAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP = 3'd4;

  // Reset values
  localparam logic [CMD_W-1:0]    MIN_COMMAND_RST = 12'd1000;
  localparam logic [CMD_W-1:0]    MAX_COMMAND_RST = 12'd2000;
  localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST  = 16'd25;
  localparam logic [FINE_W-1:0]   FINE_STEP_RST   = 8'd2;
  localparam logic [COARSE_W-1:0] COARSE_STEP_RST = 10'd50;

  localparam logic [3:0] MASK_ALL = 4'hF;

  typedef struct packed {
    logic [CMD_W-1:0]    min_command;
    logic [CMD_W-1:0]    max_command;
    logic [HOLD_W-1:0]   hold_ticks;
    logic [FINE_W-1:0]   fine_step;
    logic [COARSE_W-1:0] coarse_step;
  } cfg_t;

  typedef struct packed {
    logic              reception_ok;
    logic              reception_lost;
    logic              toggle_up;
    logic              button_lo;
    logic              button_ro;
    logic              button_li;
    logic [TICK_W-1:0] tick_now;
  } poll_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CMD_W-1:0]  command;
    logic [TICK_W-1:0] lo_press;
    logic [TICK_W-1:0] ro_press;
    logic              lo_armed;
    logic              ro_armed;
  } state_t;

  typedef struct packed {
    logic [3:0] drive_mask;
    logic       stop_motors;
  } res_t;

endpackage

/* rtl/esc_cal_cfg.sv */
// Configuration register file of the ESC calibration sequencer.
// Depends on esc_cal_pkg.
module esc_cal_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [esc_cal_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esc_cal_pkg::CFG_DATA_W-1:0]  cfg_data,
  output esc_cal_pkg::cfg_t                   cfg
);

  esc_cal_pkg::cfg_t cfg_r, cfg_nxt;

  // Writes never wait
  assign cfg_ready = 1'b1;

  // Register decode; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        esc_cal_pkg::REG_MIN_COMMAND:
          cfg_nxt.min_command = cfg_data[esc_cal_pkg::CMD_W-1:0];
        esc_cal_pkg::REG_MAX_COMMAND:
          cfg_nxt.max_command = cfg_data[esc_cal_pkg::CMD_W-1:0];
        esc_cal_pkg::REG_HOLD_TICKS:
          cfg_nxt.hold_ticks = cfg_data[esc_cal_pkg::HOLD_W-1:0];
        esc_cal_pkg::REG_FINE_STEP:
          cfg_nxt.fine_step = cfg_data[esc_cal_pkg::FINE_W-1:0];
        esc_cal_pkg::REG_COARSE_STEP:
          cfg_nxt.coarse_step = cfg_data[esc_cal_pkg::COARSE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_command <= esc_cal_pkg::MIN_COMMAND_RST;
      cfg_r.max_command <= esc_cal_pkg::MAX_COMMAND_RST;
      cfg_r.hold_ticks  <= esc_cal_pkg::HOLD_TICKS_RST;
      cfg_r.fine_step   <= esc_cal_pkg::FINE_STEP_RST;
      cfg_r.coarse_step <= esc_cal_pkg::COARSE_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/esc_cal_step.sv */
// Next-state and result logic for one poll of the calibration sequence.
// Purely combinational; depends on esc_cal_pkg.
module esc_cal_step (
  input  esc_cal_pkg::state_t st,
  input  esc_cal_pkg::poll_t  poll,
  input  esc_cal_pkg::cfg_t   cfg,
  output esc_cal_pkg::state_t st_nxt,
  output esc_cal_pkg::res_t   res
);

  typedef struct packed {
    logic                           armed;
    logic [esc_cal_pkg::TICK_W-1:0] press;
    logic                           fire;
  } hold_t;

  // Button hold timer: arm on first press, fire once past the hold time
  function automatic hold_t held_long(
    input logic                           armed,
    input logic [esc_cal_pkg::TICK_W-1:0] press,
    input logic [esc_cal_pkg::TICK_W-1:0] now,
    input logic [esc_cal_pkg::HOLD_W-1:0] hold
  );
    hold_t h;
    logic [esc_cal_pkg::TICK_W-1:0] elapsed;
    h       = '{armed: armed, press: press, fire: 1'b0};
    elapsed = now - press;
    if (!armed) begin
      h.armed = 1'b1;
      h.press = now;
    end else if (elapsed > {{(esc_cal_pkg::TICK_W-esc_cal_pkg::HOLD_W){1'b0}}, hold}) begin
      h.armed = 1'b0;
      h.fire  = 1'b1;
    end
    return h;
  endfunction

  // Limit a signed test-mode value to the command range
  function automatic logic [esc_cal_pkg::CMD_W-1:0] clamp_cmd(
    input logic signed [13:0]             v,
    input logic [esc_cal_pkg::CMD_W-1:0]  lo_lim,
    input logic [esc_cal_pkg::CMD_W-1:0]  hi_lim
  );
    logic [esc_cal_pkg::CMD_W-1:0] r;
    if (v < $signed({2'b00, lo_lim})) r = lo_lim;
    else if (v > $signed({2'b00, hi_lim})) r = hi_lim;
    else r = v[esc_cal_pkg::CMD_W-1:0];
    return r;
  endfunction

  hold_t lo_hold, ro_hold;
  logic [esc_cal_pkg::MODE_W-1:0] rel;
  logic [1:0]                     phase;
  logic [3:0]                     motor_bit;
  logic [12:0]                    sum_fine;
  logic signed [13:0]             dif_fine;
  logic signed [13:0]             test_dn;
  logic signed [13:0]             test_up;

  // Shared arithmetic for all modes
  always_comb begin
    rel       = st.mode - esc_cal_pkg::MODE_FIRST_MOTOR;
    phase     = rel[1:0];
    motor_bit = 4'b0001 << rel[3:2];
    lo_hold   = held_long(st.lo_armed, st.lo_press, poll.tick_now, cfg.hold_ticks);
    ro_hold   = held_long(st.ro_armed, st.ro_press, poll.tick_now, cfg.hold_ticks);
    sum_fine  = {1'b0, st.command} + {5'b0, cfg.fine_step};
    dif_fine  = $signed({2'b00, st.command}) - $signed({6'b0, cfg.fine_step});
    test_dn   = $signed({2'b00, st.command}) - $signed({4'b0, cfg.coarse_step});
    test_up   = $signed({2'b00, st.command}) + $signed({4'b0, cfg.coarse_step});
  end

  // Mode sequencing
  always_comb begin
    st_nxt = st;
    res    = '0;
    if (st.mode == esc_cal_pkg::MODE_CAL_MAX) begin
      if (poll.toggle_up) begin
        st_nxt.mode     = esc_cal_pkg::MODE_CAL_MIN;
        res.stop_motors = 1'b1;
      end
    end else if (st.mode == esc_cal_pkg::MODE_CAL_MIN) begin
      if (!poll.toggle_up) begin
        st_nxt.command = cfg.min_command;
        res.drive_mask = 4'b0001;
        st_nxt.mode    = esc_cal_pkg::MODE_FIRST_MOTOR;
      end
    end else if (st.mode >= esc_cal_pkg::MODE_FIRST_MOTOR &&
                 st.mode < esc_cal_pkg::MODE_TEST) begin
      if (phase == esc_cal_pkg::PH_MIN_SEARCH || phase == esc_cal_pkg::PH_MAX_SEARCH) begin
        if (poll.button_lo) begin
          st_nxt.lo_armed = lo_hold.armed;
          st_nxt.lo_press = lo_hold.press;
          if (lo_hold.fire) begin
            if (phase == esc_cal_pkg::PH_MIN_SEARCH) begin
              // step up, saturating at the upper limit
              st_nxt.command = (sum_fine > {1'b0, cfg.max_command}) ?
                               cfg.max_command : sum_fine[esc_cal_pkg::CMD_W-1:0];
            end else begin
              // step down, saturating at the lower limit
              st_nxt.command = (dif_fine < $signed({2'b00, cfg.min_command})) ?
                               cfg.min_command : dif_fine[esc_cal_pkg::CMD_W-1:0];
            end
            res.drive_mask = motor_bit;
          end
        end else if (poll.button_ro) begin
          st_nxt.lo_armed = 1'b0;
          st_nxt.command  = (phase == esc_cal_pkg::PH_MIN_SEARCH) ?
                            cfg.max_command : cfg.min_command;
          st_nxt.mode     = st.mode + 5'd1;
        end else begin
          st_nxt.lo_armed = 1'b0;
        end
      end else if (!poll.button_ro) begin
        // min or max end: RO released
        res.drive_mask = motor_bit;
        st_nxt.mode    = st.mode + 5'd1;
      end
    end else if (st.mode == esc_cal_pkg::MODE_TEST) begin
      if (poll.button_li) begin
        st_nxt.lo_armed = 1'b0;
        st_nxt.ro_armed = 1'b0;
        st_nxt.command  = cfg.min_command;
        res.drive_mask  = esc_cal_pkg::MASK_ALL;
      end else if (poll.button_lo) begin
        st_nxt.ro_armed = 1'b0;
        st_nxt.lo_armed = lo_hold.armed;
        st_nxt.lo_press = lo_hold.press;
        if (lo_hold.fire) begin
          st_nxt.command = clamp_cmd(test_dn, cfg.min_command, cfg.max_command);
          res.drive_mask = esc_cal_pkg::MASK_ALL;
        end
      end else if (poll.button_ro) begin
        st_nxt.lo_armed = 1'b0;
        st_nxt.ro_armed = ro_hold.armed;
        st_nxt.ro_press = ro_hold.press;
        if (ro_hold.fire) begin
          st_nxt.command = clamp_cmd(test_up, cfg.min_command, cfg.max_command);
          res.drive_mask = esc_cal_pkg::MASK_ALL;
        end
      end else begin
        st_nxt.lo_armed = 1'b0;
        st_nxt.ro_armed = 1'b0;
      end
      if (poll.reception_lost) st_nxt.mode = esc_cal_pkg::MODE_IDLE;
    end else begin
      // idle and unused codes
      st_nxt.mode = poll.reception_ok ? esc_cal_pkg::MODE_CAL_MAX : esc_cal_pkg::MODE_IDLE;
    end
  end

endmodule

/* rtl/esc_calibration_sequencer_core.sv */
// Top level of the ESC calibration sequencer: input register, sequence state,
// result register. Depends on esc_cal_pkg, esc_cal_cfg, esc_cal_step and the macro header.
//
//   channel | direction | handshake            | word
//   in_     | input     | in_valid / in_stall  | one poll: flags, buttons, tick
//   out_    | output    | out_valid / out_stall| mode, command, drive mask, stop
//   cfg_    | input     | cfg_valid / cfg_ready| register index and data
//
// One result per poll; each poll passes the input register, then the result register.
// A poll can be taken every cycle while in_stall is low: the state update runs between them.
// Reset (rst_n low, synchronous) returns to idle with the command at 1000.
// in_stall rises only while both registers hold a word and out_stall is high.
// cfg_ready is always high; writes take effect on the next cycle.
`include "esc_calibration_sequencer_core_macros.svh"

module esc_calibration_sequencer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // poll channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_reception_ok,
  input  logic                                in_reception_lost,
  input  logic                                in_toggle_up,
  input  logic                                in_button_lo,
  input  logic                                in_button_ro,
  input  logic                                in_button_li,
  input  logic [esc_cal_pkg::TICK_W-1:0]      in_tick_now,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [esc_cal_pkg::MODE_W-1:0]      out_mode_now,
  output logic [esc_cal_pkg::CMD_W-1:0]       out_motor_command,
  output logic [3:0]                          out_drive_mask,
  output logic                                out_stop_motors,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [esc_cal_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [esc_cal_pkg::CFG_DATA_W-1:0]  cfg_data
);

  esc_cal_pkg::cfg_t   cfg;
  esc_cal_pkg::poll_t  poll_r;
  esc_cal_pkg::state_t st_r, st_nxt;
  esc_cal_pkg::res_t   res;
  logic                in_valid_r;
  logic                out_valid_r;
  logic                advance;
  logic [esc_cal_pkg::MODE_W-1:0] out_mode_r;
  logic [esc_cal_pkg::CMD_W-1:0]  out_command_r;
  esc_cal_pkg::res_t               out_res_r;

  esc_cal_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  esc_cal_step u_step (
    .st     (st_r),
    .poll   (poll_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Held poll moves on when the result register is free or being emptied
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      poll_r <= '{reception_ok:   in_reception_ok,
                  reception_lost: in_reception_lost,
                  toggle_up:      in_toggle_up,
                  button_lo:      in_button_lo,
                  button_ro:      in_button_ro,
                  button_li:      in_button_li,
                  tick_now:       in_tick_now};
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= esc_cal_pkg::MODE_IDLE;
      st_r.command  <= esc_cal_pkg::MIN_COMMAND_RST;
      st_r.lo_press <= '0;
      st_r.ro_press <= '0;
      st_r.lo_armed <= 1'b0;
      st_r.ro_armed <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_mode_r    <= st_nxt.mode;
      out_command_r <= st_nxt.command;
      out_res_r     <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mode_now      = out_mode_r;
  assign out_motor_command = out_command_r;
  assign out_drive_mask    = out_res_r.drive_mask;
  assign out_stop_motors   = out_res_r.stop_motors;

  // Checks
  `ESC_CAL_ASSERT(a_mode_reachable, 1'b1, st_r.mode <= esc_cal_pkg::MODE_TEST)
  `ESC_CAL_ASSERT(a_stall_cause, in_stall, in_valid_r && out_valid_r && out_stall)
  `ESC_CAL_ASSERT_NEXT(a_advance_delivers, advance, out_valid_r)
  `ESC_CAL_ASSERT(a_stop_only_cal, out_valid_r && out_res_r.stop_motors,
                  out_mode_r == esc_cal_pkg::MODE_CAL_MIN && out_res_r.drive_mask == 4'b0000)
  `ESC_CAL_ASSERT(a_single_motor, out_valid_r && out_mode_r != esc_cal_pkg::MODE_TEST &&
                  out_mode_r != esc_cal_pkg::MODE_IDLE, $onehot0(out_res_r.drive_mask))

endmodule

/* tb/esc_calibration_sequencer_core_test.sv */
// Self-checking testbench for esc_calibration_sequencer_core: directed walk of the
// calibration sequence, then random polls under changing limits, idling and back-pressure.
// Depends on esc_cal_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module esc_calibration_sequencer_core_test;

  localparam int BTN_LO = 0;
  localparam int BTN_RO = 1;
  localparam int LONG_HOLD = 50;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 6;
  localparam int PHASE_POLLS = 112;
  // index past the register file; writes to it are dropped
  localparam logic [esc_cal_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // one result word of the block
  typedef struct packed {
    logic [esc_cal_pkg::MODE_W-1:0] mode;
    logic [esc_cal_pkg::CMD_W-1:0]  command;
    logic [3:0]                     drive_mask;
    logic                           stop_motors;
  } reply_t;

  // Tracks the sequencer state and the replies still owed by the block
  class calib_scoreboard;
    logic [esc_cal_pkg::CMD_W-1:0]    min_cmd;
    logic [esc_cal_pkg::CMD_W-1:0]    max_cmd;
    logic [esc_cal_pkg::HOLD_W-1:0]   hold;
    logic [esc_cal_pkg::FINE_W-1:0]   fine;
    logic [esc_cal_pkg::COARSE_W-1:0] coarse;
    logic [esc_cal_pkg::MODE_W-1:0]   mode;
    logic [esc_cal_pkg::CMD_W-1:0]    command;
    logic [esc_cal_pkg::TICK_W-1:0]   press_tick[2];
    bit                               armed[2];
    reply_t                           replies_due[$];
    int                               errors;

    function new();
      min_cmd = esc_cal_pkg::MIN_COMMAND_RST;
      max_cmd = esc_cal_pkg::MAX_COMMAND_RST;
      hold = esc_cal_pkg::HOLD_TICKS_RST;
      fine = esc_cal_pkg::FINE_STEP_RST;
      coarse = esc_cal_pkg::COARSE_STEP_RST;
      mode = esc_cal_pkg::MODE_IDLE;
      command = esc_cal_pkg::MIN_COMMAND_RST;
      press_tick[BTN_LO] = '0;
      press_tick[BTN_RO] = '0;
      armed[BTN_LO] = 1'b0;
      armed[BTN_RO] = 1'b0;
      errors = 0;
    endfunction

    function void load_reg(logic [esc_cal_pkg::CFG_IDX_W-1:0] idx,
                           logic [esc_cal_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        esc_cal_pkg::REG_MIN_COMMAND: min_cmd = data[esc_cal_pkg::CMD_W-1:0];
        esc_cal_pkg::REG_MAX_COMMAND: max_cmd = data[esc_cal_pkg::CMD_W-1:0];
        esc_cal_pkg::REG_HOLD_TICKS:  hold = data[esc_cal_pkg::HOLD_W-1:0];
        esc_cal_pkg::REG_FINE_STEP:   fine = data[esc_cal_pkg::FINE_W-1:0];
        esc_cal_pkg::REG_COARSE_STEP: coarse = data[esc_cal_pkg::COARSE_W-1:0];
        default: ;
      endcase
    endfunction

    // first press arms the timer; a press held strictly past hold fires once
    function bit hold_elapsed(int b, logic [esc_cal_pkg::TICK_W-1:0] now);
      logic [esc_cal_pkg::TICK_W-1:0] elapsed;
      if (!armed[b]) begin
        armed[b] = 1'b1;
        press_tick[b] = now;
        return 1'b0;
      end
      elapsed = now - press_tick[b];
      if (elapsed > {16'b0, hold}) begin
        armed[b] = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // signed compare against the limits; inverted limits fall out the same way
    function logic [esc_cal_pkg::CMD_W-1:0] clamp_command(int v);
      int lo_lim;
      int hi_lim;
      lo_lim = min_cmd;
      hi_lim = max_cmd;
      if (v < lo_lim) return min_cmd;
      if (v > hi_lim) return max_cmd;
      return v[esc_cal_pkg::CMD_W-1:0];
    endfunction

    // advance the sequence by one accepted poll and queue the reply it owes
    function void take_poll(esc_cal_pkg::poll_t p);
      reply_t r;
      logic [esc_cal_pkg::MODE_W-1:0] rel;
      logic [1:0] phase;
      logic [3:0] motor_bit;
      int s;
      int lo_lim;
      lo_lim = min_cmd;
      r.drive_mask = 4'b0000;
      r.stop_motors = 1'b0;
      if (mode == esc_cal_pkg::MODE_CAL_MAX) begin
        if (p.toggle_up) begin
          mode = esc_cal_pkg::MODE_CAL_MIN;
          r.stop_motors = 1'b1;
        end
      end else if (mode == esc_cal_pkg::MODE_CAL_MIN) begin
        if (!p.toggle_up) begin
          command = min_cmd;
          r.drive_mask = 4'b0001;
          mode = esc_cal_pkg::MODE_FIRST_MOTOR;
        end
      end else if (mode >= esc_cal_pkg::MODE_FIRST_MOTOR &&
                   mode < esc_cal_pkg::MODE_TEST) begin
        rel = mode - esc_cal_pkg::MODE_FIRST_MOTOR;
        motor_bit = 4'b0001 << rel[3:2];
        phase = rel[1:0];
        if (phase == esc_cal_pkg::PH_MIN_SEARCH || phase == esc_cal_pkg::PH_MAX_SEARCH) begin
          if (p.button_lo) begin
            if (hold_elapsed(BTN_LO, p.tick_now)) begin
              // fine steps saturate at the opposite limit
              if (phase == esc_cal_pkg::PH_MIN_SEARCH) begin
                s = command + fine;
                command = (s > max_cmd) ? max_cmd : s[esc_cal_pkg::CMD_W-1:0];
              end else begin
                s = command - fine;
                command = (s < lo_lim) ? min_cmd : s[esc_cal_pkg::CMD_W-1:0];
              end
              r.drive_mask = motor_bit;
            end
          end else if (p.button_ro) begin
            armed[BTN_LO] = 1'b0;
            command = (phase == esc_cal_pkg::PH_MIN_SEARCH) ? max_cmd : min_cmd;
            mode = mode + 5'd1;
          end else begin
            armed[BTN_LO] = 1'b0;
          end
        end else if (!p.button_ro) begin
          // end mode: RO released, drive the motor and move on
          r.drive_mask = motor_bit;
          mode = mode + 5'd1;
        end
      end else if (mode == esc_cal_pkg::MODE_TEST) begin
        if (p.button_li) begin
          armed[BTN_LO] = 1'b0;
          armed[BTN_RO] = 1'b0;
          command = min_cmd;
          r.drive_mask = esc_cal_pkg::MASK_ALL;
        end else if (p.button_lo) begin
          armed[BTN_RO] = 1'b0;
          if (hold_elapsed(BTN_LO, p.tick_now)) begin
            s = command;
            command = clamp_command(s - coarse);
            r.drive_mask = esc_cal_pkg::MASK_ALL;
          end
        end else if (p.button_ro) begin
          armed[BTN_LO] = 1'b0;
          if (hold_elapsed(BTN_RO, p.tick_now)) begin
            s = command;
            command = clamp_command(s + coarse);
            r.drive_mask = esc_cal_pkg::MASK_ALL;
          end
        end else begin
          armed[BTN_LO] = 1'b0;
          armed[BTN_RO] = 1'b0;
        end
        // radio loss leaves test after the button handling
        if (p.reception_lost) mode = esc_cal_pkg::MODE_IDLE;
      end else begin
        mode = p.reception_ok ? esc_cal_pkg::MODE_CAL_MAX : esc_cal_pkg::MODE_IDLE;
      end
      r.mode = mode;
      r.command = command;
      replies_due.push_back(r);
    endfunction

    function void check_result(logic [esc_cal_pkg::MODE_W-1:0] mode_now,
                               logic [esc_cal_pkg::CMD_W-1:0] cmd,
                               logic [3:0] mask, logic stop);
      reply_t e;
      if (replies_due.size() == 0) begin
        $display("%0t: result with no poll outstanding: mode %0d command %0d mask %h stop %b",
                 $time, mode_now, cmd, mask, stop);
        errors++;
        return;
      end
      e = replies_due.pop_front();
      if (mode_now !== e.mode) begin
        $display("%0t: mode_now expected %0d actual %0d", $time, e.mode, mode_now);
        errors++;
      end
      if (cmd !== e.command) begin
        $display("%0t: motor_command expected %0d actual %0d", $time, e.command, cmd);
        errors++;
      end
      if (mask !== e.drive_mask) begin
        $display("%0t: drive_mask expected %h actual %h", $time, e.drive_mask, mask);
        errors++;
      end
      if (stop !== e.stop_motors) begin
        $display("%0t: stop_motors expected %b actual %b", $time, e.stop_motors, stop);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_reception_ok = 1'b0;
  logic in_reception_lost = 1'b0;
  logic in_toggle_up = 1'b0;
  logic in_button_lo = 1'b0;
  logic in_button_ro = 1'b0;
  logic in_button_li = 1'b0;
  logic [esc_cal_pkg::TICK_W-1:0] in_tick_now = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [esc_cal_pkg::MODE_W-1:0] out_mode_now;
  logic [esc_cal_pkg::CMD_W-1:0] out_motor_command;
  logic [3:0] out_drive_mask;
  logic out_stop_motors;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [esc_cal_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [esc_cal_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  calib_scoreboard board;
  int send_gap_pct = 30;
  int rcv_stall_pct = 61;
  bit long_hold_req = 1'b0;
  int test_dice = 0;
  int quiet = 0;
  logic [esc_cal_pkg::TICK_W-1:0] tick_count = '0;

  esc_calibration_sequencer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_reception_ok   (in_reception_ok),
    .in_reception_lost (in_reception_lost),
    .in_toggle_up      (in_toggle_up),
    .in_button_lo      (in_button_lo),
    .in_button_ro      (in_button_ro),
    .in_button_li      (in_button_li),
    .in_tick_now       (in_tick_now),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mode_now      (out_mode_now),
    .out_motor_command (out_motor_command),
    .out_drive_mask    (out_drive_mask),
    .out_stop_motors   (out_stop_motors),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  // check every accepted result word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_mode_now, out_motor_command, out_drive_mask, out_stop_motors);
  end

  // watchdog: too long without any word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[esc_calibration_sequencer_core] ERROR");
      $finish;
    end
  end

  function automatic esc_cal_pkg::poll_t poll_of(input bit rok, rlost, tog, lo, ro, li,
                                                 input logic [esc_cal_pkg::TICK_W-1:0] tick);
    esc_cal_pkg::poll_t p;
    p.reception_ok = rok;
    p.reception_lost = rlost;
    p.toggle_up = tog;
    p.button_lo = lo;
    p.button_ro = ro;
    p.button_li = li;
    p.tick_now = tick;
    return p;
  endfunction

  // Random poll shaped by the predicted mode so the sequence keeps moving
  function automatic esc_cal_pkg::poll_t pick_poll();
    esc_cal_pkg::poll_t p;
    logic [63:0] raw;
    logic [esc_cal_pkg::TICK_W-1:0] span;
    logic [esc_cal_pkg::MODE_W-1:0] m;
    logic [1:0] ph;
    int dice;
    raw = {$urandom, $urandom};
    p = raw[$bits(esc_cal_pkg::poll_t)-1:0];
    // noise: every field random, tick included
    if ($urandom_range(0, 99) < 8) return p;
    // tick moves around the hold time, sometimes right on its edge
    span = {16'b0, board.hold};
    dice = $urandom_range(0, 99);
    if (dice < 10)
      tick_count = tick_count + span;
    else if (dice < 20)
      tick_count = tick_count + span + 1;
    else
      tick_count = tick_count + $urandom_range(0, span / 2 + 1);
    p.tick_now = tick_count;
    m = board.mode;
    dice = $urandom_range(0, 99);
    if (m == esc_cal_pkg::MODE_CAL_MAX || m == esc_cal_pkg::MODE_CAL_MIN) begin
      p.toggle_up = dice < 50;
    end else if (m >= esc_cal_pkg::MODE_FIRST_MOTOR && m < esc_cal_pkg::MODE_TEST) begin
      ph = 2'(m - esc_cal_pkg::MODE_FIRST_MOTOR);
      if (ph == esc_cal_pkg::PH_MIN_SEARCH || ph == esc_cal_pkg::PH_MAX_SEARCH) begin
        p.button_lo = dice < 65;
        p.button_ro = dice < 85;
      end else begin
        p.button_ro = dice < 50;
      end
    end else if (m == esc_cal_pkg::MODE_TEST) begin
      // buttons tend to stay held across polls
      if ($urandom_range(0, 99) < 30) test_dice = $urandom_range(0, 99);
      p.button_li = test_dice < 8;
      p.button_lo = test_dice >= 8 && test_dice < 45;
      p.button_ro = test_dice >= 45 && test_dice < 80;
      p.reception_lost = $urandom_range(0, 99) < 4;
    end else begin
      p.reception_ok = dice < 60;
    end
    return p;
  endfunction

  // offer one poll, with random gaps first, and hold it until taken
  task automatic drive_poll(input esc_cal_pkg::poll_t p);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_reception_ok <= p.reception_ok;
    in_reception_lost <= p.reception_lost;
    in_toggle_up <= p.toggle_up;
    in_button_lo <= p.button_lo;
    in_button_ro <= p.button_ro;
    in_button_li <= p.button_li;
    in_tick_now <= p.tick_now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_poll(p);
  endtask

  task automatic end_polls();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [esc_cal_pkg::CFG_IDX_W-1:0] idx,
                           input logic [esc_cal_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.load_reg(idx, data);
  endtask

  // unused upper data bits are random; they must be dropped
  task automatic load_limits(input logic [esc_cal_pkg::CMD_W-1:0] lo_cmd, hi_cmd,
                             input logic [esc_cal_pkg::HOLD_W-1:0] hold,
                             input logic [esc_cal_pkg::FINE_W-1:0] fine,
                             input logic [esc_cal_pkg::COARSE_W-1:0] coarse);
    write_reg(esc_cal_pkg::REG_MIN_COMMAND, {4'($urandom_range(15)), lo_cmd});
    write_reg(esc_cal_pkg::REG_MAX_COMMAND, {4'($urandom_range(15)), hi_cmd});
    write_reg(esc_cal_pkg::REG_HOLD_TICKS, hold);
    write_reg(esc_cal_pkg::REG_FINE_STEP, {8'($urandom_range(255)), fine});
    write_reg(esc_cal_pkg::REG_COARSE_STEP, {6'($urandom_range(63)), coarse});
    write_reg(REG_SPARE, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int base_cmd;
    board = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed walk through the whole sequence at reset limits
    drive_poll(poll_of(0, 0, 0, 0, 0, 0, 32'h0000_0000));
    drive_poll(poll_of(1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF));
    drive_poll(poll_of(0, 0, 1, 0, 0, 0, 32'h0000_0000)); // ESCs stopped
    drive_poll(poll_of(0, 0, 0, 0, 0, 0, 32'h0000_0000));
    drive_poll(poll_of(0, 0, 0, 1, 0, 0, 32'hFFFF_FFF0)); // LO arms
    drive_poll(poll_of(0, 0, 0, 1, 0, 0, 32'h0000_0009)); // exactly hold, across wrap
    drive_poll(poll_of(0, 0, 0, 1, 0, 0, 32'h0000_000A)); // one past: step up
    drive_poll(poll_of(0, 0, 0, 0, 1, 0, 32'h0000_000A));
    drive_poll(poll_of(0, 0, 0, 0, 0, 0, 32'h0000_000B));
    drive_poll(poll_of(0, 0, 0, 1, 0, 0, 32'h0000_0064));
    drive_poll(poll_of(0, 0, 0, 1, 0, 0, 32'h0000_00C8)); // step down
    drive_poll(poll_of(0, 0, 0, 0, 1, 0, 32'h0000_00C8));
    drive_poll(poll_of(0, 0, 0, 0, 0, 0, 32'h0000_00C8));
    // remaining motors: RO press and release through each end mode
    for (int k = 0; k < 3; k++) begin
      drive_poll(poll_of(0, 0, 0, 0, 1, 0, 32'h0000_0000));
      drive_poll(poll_of(0, 0, 0, 0, 0, 0, 32'h0000_0000));
      drive_poll(poll_of(0, 0, 0, 0, 1, 0, 32'h0000_0000));
      drive_poll(poll_of(0, 0, 0, 0, 0, 0, 32'h0000_0000));
    end
    // test mode: LI to min, RO held past hold while radio drops
    drive_poll(poll_of(0, 0, 0, 0, 0, 1, 32'h0000_0000));
    drive_poll(poll_of(0, 0, 0, 0, 1, 0, 32'h0000_03E8));
    drive_poll(poll_of(0, 1, 0, 0, 1, 0, 32'h0000_0402));
    end_polls();

    // random phases, each under its own limits and idling
    for (int ph = 0; ph < 6; ph++) begin
      send_gap_pct = (ph % 3 == 0) ? 30 : (ph % 3 == 1) ? 61 : 0;
      rcv_stall_pct = (ph % 3 == 0) ? 61 : (ph % 3 == 1) ? 30 : 0;
      if (ph > 0) wait_drained();
      case (ph)
        1: load_limits(12'd0, 12'd4095, 16'd0, 8'd255, 10'd1023);
        2: begin
          // inverted limits, longest hold, zero steps
          load_limits(12'd4095, 12'd0, 16'hFFFF, 8'd0, 10'd0);
          tick_count = 32'hFFFF_0000;
        end
        4: load_limits(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       16'($urandom), 8'($urandom_range(0, 255)),
                       10'($urandom_range(0, 1023)));
        3, 5: begin
          base_cmd = $urandom_range(0, 3000);
          load_limits(12'(base_cmd), 12'(base_cmd + $urandom_range(0, 400)),
                      16'($urandom_range(0, 30)), 8'($urandom_range(1, 255)),
                      10'($urandom_range(0, 1023)));
        end
        default: ;
      endcase
      // last phase: result side holds off while polls keep coming
      if (ph == 5) long_hold_req = 1'b1;
      repeat (PHASE_POLLS) drive_poll(pick_poll());
      end_polls();
    end

    wait_drained();
    if (board.errors == 0)
      $display("[esc_calibration_sequencer_core] OK");
    else
      $display("[esc_calibration_sequencer_core] ERROR");
    $finish;
  end

endmodule
